// ----- rtl/spmf_pkg.sv -----
// Shared types, codes and sizes of the strict-priority multi-level queue.
package spmf_pkg;

    localparam int DATA_WIDTH   = 8;
    localparam int FUNC_W       = 2;
    localparam int PRIO_W       = 4;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 7;
    localparam int DEF_LEVELS   = 11;
    localparam int DEF_CAPACITY = 64;
    localparam logic [PRIO_W-1:0] MAX_PRIO_RESET = 4'd10;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_DEQUEUE = 2'd1,
        FUNC_PEEK    = 2'd2,
        FUNC_QUERY   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_PRIO = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [DATA_WIDTH-1:0] data_in;
        logic [PRIO_W-1:0]     priority_req;
    } in_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_out;
        logic [STATUS_W-1:0]   status;
        logic                  is_empty;
        logic [TOTAL_W-1:0]    item_total;
    } out_item_t;

endpackage

// ----- rtl/spmf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module spmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/strict_priority_multi_fifo.sv -----
// Top level of the strict-priority multi-level queue.
//
// Items enter on the s_ channel (valid/ready) as an operation: enqueue a byte
// at a priority level, dequeue, peek, or query. Each item gives exactly one
// result on the m_ channel (valid/ready) with data, status, empty flag and
// the number of items held. Level 0 is served first; within a level order is
// first in, first out. All levels share one linked-list entry store of
// CAPACITY entries kept in two RAMs (data and link).
// The cfg_ channel writes max_priority; write it only while no item is open.
// An item passes through the idle and execute states: the accept in the idle
// state issues the RAM reads, and the execute state takes the registered read
// data and writes back. s_ready is high only in the idle state, so a new
// item is taken only after the current one has written back. A result
// waits in an output register while m_ready is low; the next item may still
// be accepted, and its write-back holds until the waiting result is taken.
// Reset (aresetn low, synchronous) empties all levels, sets max_priority to
// 10 and needs no clearing pass: fresh entries are handed out in order by a
// counter and freed entries are stacked through the link RAM.
module strict_priority_multi_fifo
    import spmf_pkg::*;
#(
    parameter int LEVELS   = DEF_LEVELS,
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PRIO_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [31:0] TOP_LEVEL = 32'(LEVELS - 1);

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic [IDX_W-1:0] head_reg [LEVELS];
    logic [IDX_W-1:0] tail_reg [LEVELS];
    logic [LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PRIO_W-1:0] max_prio_reg;

    logic accept;
    logic commit;
    logic [LVL_W-1:0] lvl_comb;
    logic [IDX_W-1:0] rd_head;
    logic [IDX_W-1:0] link_raddr;
    logic [DATA_WIDTH-1:0] data_rdata;
    logic [IDX_W-1:0] link_rdata;

    logic data_we;
    logic [IDX_W-1:0] data_waddr;
    logic link_we;
    logic [IDX_W-1:0] link_waddr;
    logic [IDX_W-1:0] link_wdata;

    logic head_we;
    logic [LVL_W-1:0] head_idx;
    logic [IDX_W-1:0] head_wdata;
    logic tail_we;
    logic [IDX_W-1:0] tail_wdata;

    logic [31:0] prio_wide;
    logic [31:0] max_wide;
    logic [31:0] eff_max;
    logic [LVL_W-1:0] prio_idx;
    logic [IDX_W-1:0] new_entry;
    logic [IDX_W-1:0] old_entry;
    logic [31:0] total_wide;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    always_comb begin
        lvl_comb = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (nonempty_reg[i]) begin
                lvl_comb = LVL_W'(i);
            end
        end
    end

    assign rd_head    = head_reg[lvl_comb];
    assign link_raddr = (s_item.func == FUNC_ENQUEUE) ? free_head_reg : rd_head;

    spmf_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(CAPACITY)
    ) u_data_ram (
        .aclk (aclk),
        .we   (data_we),
        .waddr(data_waddr),
        .wdata(item_reg.data_in),
        .re   (accept),
        .raddr(rd_head),
        .rdata(data_rdata)
    );

    spmf_ram #(
        .WIDTH(IDX_W),
        .DEPTH(CAPACITY)
    ) u_link_ram (
        .aclk (aclk),
        .we   (link_we),
        .waddr(link_waddr),
        .wdata(link_wdata),
        .re   (accept),
        .raddr(link_raddr),
        .rdata(link_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_ready = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: commit = !out_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
                commit  = 1'b0;
            end
        endcase
    end

    assign prio_wide = 32'(item_reg.priority_req);
    assign max_wide  = 32'(max_prio_reg);
    assign eff_max   = (max_wide > TOP_LEVEL) ? TOP_LEVEL : max_wide;
    assign prio_idx  = prio_wide[LVL_W-1:0];
    assign new_entry = (fresh_reg != count_reg) ? free_head_reg : fresh_reg[IDX_W-1:0];
    assign old_entry = head_reg[lvl_reg];

    // Operation and write-back.
    always_comb begin
        nonempty_next  = nonempty_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        data_we        = 1'b0;
        data_waddr     = new_entry;
        link_we        = 1'b0;
        link_waddr     = tail_reg[prio_idx];
        link_wdata     = new_entry;
        head_we        = 1'b0;
        head_idx       = prio_idx;
        head_wdata     = new_entry;
        tail_we        = 1'b0;
        tail_wdata     = new_entry;
        out_item_next  = out_item_reg;
        out_item_next.data_out = '0;
        out_item_next.status   = STATUS_OK;

        case (item_reg.func)
            FUNC_ENQUEUE: begin
                if (prio_wide > eff_max) begin
                    out_item_next.status = STATUS_BAD_PRIO;
                end else if (count_reg == CAP_CNT) begin
                    out_item_next.status = STATUS_FULL;
                end else begin
                    data_we = commit;
                    tail_we = commit;
                    if (fresh_reg != count_reg) begin
                        free_head_next = link_rdata;
                    end else begin
                        fresh_next = fresh_reg + 1'b1;
                    end
                    if (nonempty_reg[prio_idx]) begin
                        link_we = commit;
                    end else begin
                        head_we = commit;
                        nonempty_next[prio_idx] = 1'b1;
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_DEQUEUE, FUNC_PEEK: begin
                if (nonempty_reg == '0) begin
                    out_item_next.status = STATUS_EMPTY;
                end else begin
                    out_item_next.data_out = data_rdata;
                    if (item_reg.func == FUNC_DEQUEUE) begin
                        head_idx = lvl_reg;
                        if (old_entry == tail_reg[lvl_reg]) begin
                            nonempty_next[lvl_reg] = 1'b0;
                        end else begin
                            head_we    = commit;
                            head_wdata = link_rdata;
                        end
                        link_we        = commit;
                        link_waddr     = old_entry;
                        link_wdata     = free_head_reg;
                        free_head_next = old_entry;
                        count_next     = count_reg - 1'b1;
                    end
                end
            end
            default: begin
                out_item_next.status = STATUS_OK;
            end
        endcase

        total_wide = 32'(count_next);
        out_item_next.is_empty   = (count_next == '0);
        out_item_next.item_total = total_wide[TOTAL_W-1:0];

        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            nonempty_reg  <= '0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            max_prio_reg  <= MAX_PRIO_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit) begin
                nonempty_reg  <= nonempty_next;
                free_head_reg <= free_head_next;
                fresh_reg     <= fresh_next;
                count_reg     <= count_next;
            end
            if (cfg_valid) begin
                max_prio_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
            lvl_reg  <= lvl_comb;
        end
        if (commit) begin
            out_item_reg <= out_item_next;
        end
        if (head_we) begin
            head_reg[head_idx] <= head_wdata;
        end
        if (tail_we) begin
            tail_reg[prio_idx] <= tail_wdata;
        end
    end

endmodule
